### rtl/cctd_pkg.sv
package cctd_pkg;

    localparam int unsigned WORD_W = 15;
    localparam int unsigned DATA_W = 7;
    localparam int unsigned CNT_W  = 3;

    localparam logic CODE_15_7 = 1'b0;
    localparam logic CODE_15_5 = 1'b1;

    localparam logic [8:0]  G_15_7   = 9'h1D1;
    localparam logic [10:0] G_15_5   = 11'h537;
    localparam int unsigned DEG_15_7 = 8;
    localparam int unsigned DEG_15_5 = 10;

    localparam logic [CNT_W-1:0] K_15_7 = 3'd7;
    localparam logic [CNT_W-1:0] K_15_5 = 3'd5;
    localparam logic [3:0]       T_15_7 = 4'd2;
    localparam logic [3:0]       T_15_5 = 4'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TRIAL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] data;
    } t_trial_res;

endpackage

### rtl/cctd_in_if.sv
interface cctd_in_if;
    logic                        valid;
    logic                        ready;
    logic [cctd_pkg::WORD_W-1:0] received_word;

    modport source (output valid, output received_word, input ready);
    modport sink   (input valid, input received_word, output ready);
endinterface

### rtl/cctd_out_if.sv
interface cctd_out_if;
    logic                        valid;
    logic                        ready;
    logic [cctd_pkg::DATA_W-1:0] data_bits;
    logic                        decode_failed;

    modport source (output valid, output data_bits, output decode_failed, input ready);
    modport sink   (input valid, input data_bits, input decode_failed, output ready);
endinterface

### rtl/cyclic_code_error_trap_decoder.sv
// Error-trapping decoder for the length-15 BCH codes: code_mode 0 selects the
// (15,7) double-error code, code_mode 1 the (15,5) triple-error code. One item
// is taken, then one syndrome trial per cycle runs through a single shared
// remainder/weight unit, rotating the word between trials, for at most k+1
// trials (8 for the (15,7) code, 6 for the (15,5) code). The result sits in an
// output register until taken; the next item is accepted the cycle after.
// Each item thus passes through accept, its trials and output, in that order.
// decode_failed with zero data_bits marks a word no trial could correct.
// Write code_mode only while no item is in flight.
module cyclic_code_error_trap_decoder (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_data,
    cctd_in_if.sink    i_in,
    cctd_out_if.source o_out
);
    import cctd_pkg::*;

    t_state            r_state, n_state;
    logic              r_mode;
    logic [WORD_W-1:0] r_word, n_word;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DATA_W-1:0] r_data, n_data;
    logic              r_fail, n_fail;
    logic [CNT_W-1:0]  k_last;
    t_trial_res        trial;

    cctd_trial u_trial (
        .i_word (r_word),
        .i_rot  (r_cnt),
        .i_mode (r_mode),
        .o_res  (trial)
    );

    assign k_last = (r_mode == CODE_15_5) ? K_15_5 : K_15_7;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_TRIAL;
                end
            end
            S_TRIAL: begin
                if (trial.hit || r_cnt == k_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready          = (r_state == S_IDLE);
        o_out.valid         = (r_state == S_OUT);
        o_out.data_bits     = r_data;
        o_out.decode_failed = r_fail;
    end

    always_comb begin
        n_word = r_word;
        n_cnt  = r_cnt;
        n_data = r_data;
        n_fail = r_fail;
        if (r_state == S_IDLE) begin
            n_word = i_in.received_word;
            n_cnt  = '0;
        end else if (r_state == S_TRIAL) begin
            if (trial.hit) begin
                n_data = trial.data;
                n_fail = 1'b0;
            end else if (r_cnt == k_last) begin
                n_data = '0;
                n_fail = 1'b1;
            end else begin
                n_word = {r_word[WORD_W-2:0], r_word[WORD_W-1]};
                n_cnt  = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= CODE_15_7;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_cnt  <= n_cnt;
        r_data <= n_data;
        r_fail <= n_fail;
    end

endmodule

### rtl/cctd_trial.sv
module cctd_trial (
    input  logic [cctd_pkg::WORD_W-1:0] i_word,
    input  logic [cctd_pkg::CNT_W-1:0]  i_rot,
    input  logic                        i_mode,
    output cctd_pkg::t_trial_res        o_res
);
    import cctd_pkg::*;

    function automatic logic [DEG_15_7-1:0] rem_15_7(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        r = w;
        for (int b = WORD_W - 1; b >= int'(DEG_15_7); b--) begin
            if (r[b]) begin
                r = r ^ (WORD_W'(G_15_7) << (b - int'(DEG_15_7)));
            end
        end
        return r[DEG_15_7-1:0];
    endfunction

    function automatic logic [DEG_15_5-1:0] rem_15_5(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        r = w;
        for (int b = WORD_W - 1; b >= int'(DEG_15_5); b--) begin
            if (r[b]) begin
                r = r ^ (WORD_W'(G_15_5) << (b - int'(DEG_15_5)));
            end
        end
        return r[DEG_15_5-1:0];
    endfunction

    logic [WORD_W-1:0]   syn;
    logic [3:0]          wgt;
    logic [3:0]          t_max;
    logic [WORD_W-1:0]   fixed;
    logic [2*WORD_W-1:0] dbl;
    logic [WORD_W-1:0]   back;

    always_comb begin
        if (i_mode == CODE_15_5) begin
            syn   = {5'd0, rem_15_5(i_word)};
            t_max = T_15_5;
        end else begin
            syn   = {7'd0, rem_15_7(i_word)};
            t_max = T_15_7;
        end
        wgt   = 4'($countones(syn));
        fixed = i_word ^ syn;
        dbl   = {fixed, fixed} >> i_rot;
        back  = dbl[WORD_W-1:0];
        o_res.hit = (wgt <= t_max);
        if (i_mode == CODE_15_5) begin
            o_res.data = {2'd0, back[WORD_W-1:WORD_W-5]};
        end else begin
            o_res.data = back[WORD_W-1:WORD_W-DATA_W];
        end
    end

endmodule

### tb/sv/cyclic_code_error_trap_decoder_tb.sv
module cyclic_code_error_trap_decoder_tb;
    import cctd_pkg::*;

    localparam logic [14:0] GPOLY_DBL   = 15'h01D1;
    localparam logic [14:0] GPOLY_TRP   = 15'h0537;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          SHOW_LIMIT   = 10;

    typedef struct packed {
        logic [6:0] data;
        logic       failed;
    } t_decoded;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_data;

    cctd_in_if  chan_in ();
    cctd_out_if chan_out ();

    cyclic_code_error_trap_decoder dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in      (chan_in),
        .o_out     (chan_out)
    );

    t_decoded pending_words[$];
    t_decoded got_word;
    t_decoded want_word;
    logic     active_mode;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       cycle_count;
    int       n_bad;
    int       n_sent_dbl;
    int       n_sent_trp;
    int       n_corrected;
    int       n_uncorrectable;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d items outstanding",
                 cycle_count, pending_words.size());
        $display("cyclic_code_error_trap_decoder verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic [14:0] syndrome_of(input logic mode, input logic [14:0] word);
        logic [14:0] rem;
        logic [14:0] gen;
        int          deg;
        rem = word;
        gen = (mode == CODE_15_5) ? GPOLY_TRP : GPOLY_DBL;
        deg = (mode == CODE_15_5) ? 10 : 8;
        for (int b = 14; b >= deg; b--) begin
            if (rem[b]) begin
                rem = rem ^ (gen << (b - deg));
            end
        end
        return rem;
    endfunction

    function automatic t_decoded decode_word(input logic mode, input logic [14:0] word);
        t_decoded    res;
        logic [14:0] w;
        logic [14:0] syn;
        logic [14:0] fixed;
        int          k;
        int          t;
        k = (mode == CODE_15_5) ? 5 : 7;
        t = (mode == CODE_15_5) ? 3 : 2;
        res.data = '0;
        res.failed = 1'b1;
        w = word;
        for (int i = 0; i <= k; i++) begin
            syn = syndrome_of(mode, w);
            if ($countones(syn) <= t) begin
                fixed = w ^ syn;
                for (int j = 0; j < i; j++) begin
                    fixed = {fixed[0], fixed[14:1]};
                end
                res.data = 7'(fixed >> (15 - k));
                res.failed = 1'b0;
                return res;
            end
            w = {w[13:0], w[14]};
        end
        return res;
    endfunction

    function automatic logic [14:0] encode_data(input logic mode, input int unsigned data);
        logic [14:0] shifted;
        if (mode == CODE_15_5) begin
            shifted = 15'(data & 32'h1F) << 10;
        end else begin
            shifted = 15'(data & 32'h7F) << 8;
        end
        return shifted ^ syndrome_of(mode, shifted);
    endfunction

    function automatic logic [14:0] error_pattern(input int weight);
        logic [14:0] e;
        e = '0;
        for (int i = 0; i < weight; i++) begin
            e[$urandom_range(14)] = 1'b1;
        end
        return e;
    endfunction

    task automatic report_mismatch(input string what);
        n_bad++;
        if (n_bad <= SHOW_LIMIT) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
    endtask

    // receiver: drop ready at random, check each item taken
    always @(negedge i_clk) begin
        chan_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && chan_out.valid && chan_out.ready) begin
            got_word.data = chan_out.data_bits;
            got_word.failed = chan_out.decode_failed;
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected item data=%0h failed=%0b",
                                          got_word.data, got_word.failed));
            end else begin
                want_word = pending_words.pop_front();
                if (got_word.failed) begin
                    n_uncorrectable++;
                end else begin
                    n_corrected++;
                end
                if (got_word.data !== want_word.data) begin
                    report_mismatch($sformatf("data_bits expected %0h got %0h",
                                              want_word.data, got_word.data));
                end
                if (got_word.failed !== want_word.failed) begin
                    report_mismatch($sformatf("decode_failed expected %0b got %0b",
                                              want_word.failed, got_word.failed));
                end
            end
        end
    end

    task automatic send_word(input logic [14:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            chan_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        chan_in.valid <= 1'b1;
        chan_in.received_word <= word;
        @(posedge i_clk);
        while (!chan_in.ready) begin
            @(posedge i_clk);
        end
        pending_words = {pending_words, decode_word(active_mode, word)};
        if (active_mode == CODE_15_5) begin
            n_sent_trp++;
        end else begin
            n_sent_dbl++;
        end
        @(negedge i_clk);
    endtask

    task automatic drain_results;
        chan_in.valid <= 1'b0;
        while (pending_words.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_code_mode(input logic mode);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_data <= mode;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        active_mode = mode;
    endtask

    task automatic test_special_words(input logic mode);
        set_code_mode(mode);
        send_word(15'h0000);
        send_word(15'h7FFF);
        send_word(15'h5555);
        send_word(15'h2AAA);
        send_word(encode_data(mode, 32'h7F));
    endtask

    task automatic test_error_patterns(input logic mode);
        logic [14:0] cw;
        set_code_mode(mode);
        cw = encode_data(mode, $urandom);
        send_word(cw ^ 15'h4000);
        send_word(cw ^ 15'h0001);
        send_word(cw ^ ((mode == CODE_15_5) ? 15'h7000 : 15'h6000));
        send_word(cw ^ ((mode == CODE_15_5) ? 15'h4081 : 15'h4001));
        send_word(cw ^ ((mode == CODE_15_5) ? 15'h0380 : 15'h0180));
        send_word(cw ^ ((mode == CODE_15_5) ? 15'h4821 : 15'h4210));
        send_word(15'($urandom));
    endtask

    task automatic test_random_traffic(input logic mode, input int n_items);
        int          sel;
        int          t;
        logic [14:0] cw;
        set_code_mode(mode);
        t = (mode == CODE_15_5) ? 3 : 2;
        for (int n = 0; n < n_items; n++) begin
            sel = $urandom_range(99);
            cw = encode_data(mode, $urandom);
            if (sel < 65) begin
                send_word(cw ^ error_pattern($urandom_range(t, 0)));
            end else if (sel < 85) begin
                send_word(cw ^ error_pattern(t + 1 + $urandom_range(1)));
            end else begin
                send_word(15'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 1'b0;
        chan_in.valid = 1'b0;
        chan_in.received_word = '0;
        chan_out.ready = 1'b0;
        active_mode = CODE_15_7;
        n_bad = 0;
        n_sent_dbl = 0;
        n_sent_trp = 0;
        n_corrected = 0;
        n_uncorrectable = 0;
        send_idle_pct = 12;
        recv_idle_pct = 78;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_special_words(CODE_15_7);
        test_error_patterns(CODE_15_7);
        test_special_words(CODE_15_5);
        test_error_patterns(CODE_15_5);

        test_random_traffic(CODE_15_7, 300);
        test_random_traffic(CODE_15_5, 300);

        send_idle_pct = 78;
        recv_idle_pct = 12;
        test_random_traffic(CODE_15_7, 300);
        test_random_traffic(CODE_15_5, 300);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(CODE_15_5, 325);
        test_random_traffic(CODE_15_7, 325);
        drain_results();

        $display("decoded %0d words: %0d as (15,7), %0d as (15,5)",
                 n_sent_dbl + n_sent_trp, n_sent_dbl, n_sent_trp);
        $display("%0d corrected, %0d uncorrectable, %0d mismatches",
                 n_corrected, n_uncorrectable, n_bad);
        if (n_bad == 0 && pending_words.size() == 0) begin
            $display("cyclic_code_error_trap_decoder verification clean");
        end else begin
            $display("cyclic_code_error_trap_decoder verification failed");
        end
        $finish;
    end
endmodule
